/* rtl/core/cmh_pkg.sv */
// ----------------------------------------------------------------------------
// cmh_pkg
// Shared types and constants for the climate mist/heat controller: register
// indexes, reset values, request codes and stream beat layouts.
// ----------------------------------------------------------------------------
package cmh_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_HUMIDITY_SETPOINT    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TEMPERATURE_SETPOINT = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_HUMIDITY_MARGIN      = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_TICKS_PER_SECOND     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_BURST_SECONDS        = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_WAIT_SECONDS         = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_ATTEMPT_LIMIT        = 3'd6;

   localparam logic [6:0]        RST_HUMIDITY_SETPOINT    = 7'd70;
   localparam logic signed [9:0] RST_TEMPERATURE_SETPOINT = 10'sd75;
   localparam logic [6:0]        RST_HUMIDITY_MARGIN      = 7'd10;
   localparam logic [7:0]        RST_TICKS_PER_SECOND     = 8'd60;
   localparam logic [7:0]        RST_BURST_SECONDS        = 8'd3;
   localparam logic [15:0]       RST_WAIT_SECONDS         = 16'd300;
   localparam logic [3:0]        RST_ATTEMPT_LIMIT        = 4'd4;

   localparam logic [1:0] REQ_ENABLE  = 2'd1;
   localparam logic [1:0] REQ_DISABLE = 2'd2;

   localparam logic [5:0] SECOND_TOP = 6'd59;
   localparam logic [5:0] MINUTE_TOP = 6'd59;
   localparam logic [4:0] HOUR_TOP   = 5'd23;

   localparam int ReqDataWidth = 32;
   localparam int RspDataWidth = 24;

   typedef struct packed {
      logic [1:0]        heat_request;
      logic [1:0]        mist_request;
      logic              bus_fault;
      logic              cold_sensor_fault;
      logic              warm_sensor_fault;
      logic signed [7:0] cold_humidity;
      logic signed [9:0] warm_temperature;
   } req_beat_type;

   typedef struct packed {
      logic [5:0] clock_seconds;
      logic [5:0] clock_minutes;
      logic [4:0] clock_hours;
      logic       second_pulse;
      logic       any_fault;
      logic       mist_gave_up;
      logic       heat_enabled;
      logic       mist_enabled;
      logic       heater_on;
      logic       mister_on;
   } rsp_beat_type;

endpackage

/* rtl/core/climate_mist_heat_controller_top.sv */
// ----------------------------------------------------------------------------
// climate_mist_heat_controller_top
// Tick-driven mist burst and on/off heater controller with a running clock.
//
//   channel | dir | width | content
//   req_    | in  | 32    | one tick: readings, fault flags, requests
//   rsp_    | out | 24    | drives, enables, faults, clock after the tick
//   csr_    | in  | 16    | register writes, index 0..6
//
// One beat per clock unless rsp_ stalls: each accepted tick updates all
// state in the same cycle and lands in the result register. req_tready
// is high while the result register is empty or being taken, so a stalled rsp_
// side holds one beat. Synchronous reset clears the clock, controller state,
// faults and drives and reloads the registers with their default values.
// ----------------------------------------------------------------------------
module climate_mist_heat_controller_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // warm_temperature[9:0], cold_humidity[17:10], warm_sensor_fault[18],
   // cold_sensor_fault[19], bus_fault[20], mist_request[22:21],
   // heat_request[24:23], zero[31:25]
   input  logic [cmh_pkg::ReqDataWidth-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // mister_on[0], heater_on[1], mist_enabled[2], heat_enabled[3],
   // mist_gave_up[4], any_fault[5], second_pulse[6], clock_hours[11:7],
   // clock_minutes[17:12], clock_seconds[23:18]
   output logic [cmh_pkg::RspDataWidth-1:0]  rsp_tdata,
   input  logic                              csr_wen,
   input  logic [cmh_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [cmh_pkg::CsrDataWidth-1:0]  csr_wdata
);

   cmh_pkg::req_beat_type req;
   cmh_pkg::rsp_beat_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff;
   logic                  accept;

   logic [6:0]        hum_set_ff;
   logic signed [9:0] temp_set_ff;
   logic [6:0]        hum_margin_ff;
   logic [7:0]        tps_ff;
   logic [7:0]        burst_secs_ff;
   logic [15:0]       wait_secs_ff;
   logic [3:0]        attempt_limit_ff;

   logic [7:0]  tick_ff, tick_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic        mist_act_ff, mist_act_in;
   logic        mist_en_ff, mist_en_in;
   logic [7:0]  burst_el_ff, burst_el_in;
   logic [15:0] wait_el_ff, wait_el_in;
   logic [3:0]  attempts_ff, attempts_in;
   logic        heat_act_ff, heat_act_in;
   logic        heat_en_ff, heat_en_in;
   logic        flt_warm_ff, flt_warm_in;
   logic        flt_cold_ff, flt_cold_in;
   logic        flt_mist_ff, flt_mist_in;
   logic        mister_ff, mister_in;
   logic        heater_ff, heater_in;

   assign req        = cmh_pkg::req_beat_type'(req_tdata[$bits(cmh_pkg::req_beat_type)-1:0]);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hum_set_ff       <= cmh_pkg::RST_HUMIDITY_SETPOINT;
         temp_set_ff      <= cmh_pkg::RST_TEMPERATURE_SETPOINT;
         hum_margin_ff    <= cmh_pkg::RST_HUMIDITY_MARGIN;
         tps_ff           <= cmh_pkg::RST_TICKS_PER_SECOND;
         burst_secs_ff    <= cmh_pkg::RST_BURST_SECONDS;
         wait_secs_ff     <= cmh_pkg::RST_WAIT_SECONDS;
         attempt_limit_ff <= cmh_pkg::RST_ATTEMPT_LIMIT;
      end else if (csr_wen) begin
         unique case (csr_index)
            cmh_pkg::CSR_HUMIDITY_SETPOINT:    hum_set_ff       <= csr_wdata[6:0];
            cmh_pkg::CSR_TEMPERATURE_SETPOINT: temp_set_ff      <= signed'(csr_wdata[9:0]);
            cmh_pkg::CSR_HUMIDITY_MARGIN:      hum_margin_ff    <= csr_wdata[6:0];
            cmh_pkg::CSR_TICKS_PER_SECOND:     tps_ff           <= csr_wdata[7:0];
            cmh_pkg::CSR_BURST_SECONDS:        burst_secs_ff    <= csr_wdata[7:0];
            cmh_pkg::CSR_WAIT_SECONDS:         wait_secs_ff     <= csr_wdata;
            cmh_pkg::CSR_ATTEMPT_LIMIT:        attempt_limit_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic              sec_pulse;
      logic [8:0]        tick_next;
      logic signed [8:0] mist_thresh;
      logic [7:0]        burst_cnt;
      logic [15:0]       wait_cnt;

      tick_in     = tick_ff;
      sec_in      = sec_ff;
      min_in      = min_ff;
      hour_in     = hour_ff;
      mist_act_in = mist_act_ff;
      mist_en_in  = mist_en_ff;
      burst_el_in = burst_el_ff;
      wait_el_in  = wait_el_ff;
      attempts_in = attempts_ff;
      heat_act_in = heat_act_ff;
      heat_en_in  = heat_en_ff;
      flt_warm_in = flt_warm_ff | req.warm_sensor_fault;
      flt_cold_in = flt_cold_ff | req.cold_sensor_fault;
      flt_mist_in = flt_mist_ff;
      mister_in   = mister_ff;
      heater_in   = heater_ff;

      if (req.mist_request == cmh_pkg::REQ_ENABLE) begin
         mist_en_in = 1'b1;
      end else if (req.mist_request == cmh_pkg::REQ_DISABLE) begin
         mist_en_in = 1'b0;
      end
      if (req.heat_request == cmh_pkg::REQ_ENABLE) begin
         heat_en_in = 1'b1;
      end else if (req.heat_request == cmh_pkg::REQ_DISABLE) begin
         heat_en_in = 1'b0;
      end

      // clock
      tick_next = {1'b0, tick_ff} + 9'd1;
      sec_pulse = tick_next >= {1'b0, tps_ff};
      if (sec_pulse) begin
         tick_in = '0;
         if (sec_ff >= cmh_pkg::SECOND_TOP) begin
            sec_in = '0;
            if (min_ff >= cmh_pkg::MINUTE_TOP) begin
               min_in  = '0;
               hour_in = (hour_ff >= cmh_pkg::HOUR_TOP) ? '0 : hour_ff + 5'd1;
            end else begin
               min_in = min_ff + 6'd1;
            end
         end else begin
            sec_in = sec_ff + 6'd1;
         end
      end else begin
         tick_in = tick_next[7:0];
      end

      // mist bursts
      mist_thresh = signed'({2'b00, hum_set_ff}) - signed'({2'b00, hum_margin_ff});
      burst_cnt   = (sec_pulse && burst_el_ff != 8'hFF) ? burst_el_ff + 8'd1 : burst_el_ff;
      wait_cnt    = (sec_pulse && wait_el_ff != 16'hFFFF) ? wait_el_ff + 16'd1 : wait_el_ff;
      if (!mist_en_in ||
          (!req.cold_humidity[7] && 9'(req.cold_humidity) >= mist_thresh)) begin
         mist_act_in = 1'b0;
         burst_el_in = '0;
         wait_el_in  = '0;
         attempts_in = '0;
      end else if (req.cold_humidity[7]) begin
         mist_en_in = 1'b0;
      end else if (mist_act_ff) begin
         if (burst_cnt >= burst_secs_ff) begin
            mist_act_in = 1'b0;
            burst_el_in = '0;
            attempts_in = (attempts_ff != 4'hF) ? attempts_ff + 4'd1 : attempts_ff;
         end else begin
            burst_el_in = burst_cnt;
         end
      end else begin
         wait_el_in = wait_cnt;
         if (attempts_ff == '0 || wait_cnt >= wait_secs_ff) begin
            if (attempts_ff >= attempt_limit_ff) begin
               mist_en_in  = 1'b0;
               flt_mist_in = 1'b1;
            end else begin
               mist_act_in = 1'b1;
               wait_el_in  = '0;
            end
         end
      end

      // heater, on/off with no band
      if (!heat_en_in) begin
         heat_act_in = 1'b0;
      end else if (req.warm_temperature[9]) begin
         heat_en_in = 1'b0;
      end else if (heat_act_ff) begin
         if (req.warm_temperature > temp_set_ff) begin
            heat_act_in = 1'b0;
         end
      end else if (req.warm_temperature < temp_set_ff) begin
         heat_act_in = 1'b1;
      end

      if (req.bus_fault || flt_warm_in) begin
         heat_en_in = 1'b0;
      end
      if (req.bus_fault || flt_cold_in || flt_mist_in) begin
         mist_en_in = 1'b0;
      end

      if (sec_pulse) begin
         mister_in = mist_act_in;
         heater_in = heat_act_in;
      end

      rsp_in.mister_on     = mister_in;
      rsp_in.heater_on     = heater_in;
      rsp_in.mist_enabled  = mist_en_in;
      rsp_in.heat_enabled  = heat_en_in;
      rsp_in.mist_gave_up  = flt_mist_in;
      rsp_in.any_fault     = flt_warm_in | flt_cold_in | flt_mist_in | req.bus_fault;
      rsp_in.second_pulse  = sec_pulse;
      rsp_in.clock_hours   = hour_in;
      rsp_in.clock_minutes = min_in;
      rsp_in.clock_seconds = sec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         sec_ff       <= '0;
         min_ff       <= '0;
         hour_ff      <= '0;
         mist_act_ff  <= 1'b0;
         mist_en_ff   <= 1'b0;
         burst_el_ff  <= '0;
         wait_el_ff   <= '0;
         attempts_ff  <= '0;
         heat_act_ff  <= 1'b0;
         heat_en_ff   <= 1'b0;
         flt_warm_ff  <= 1'b0;
         flt_cold_ff  <= 1'b0;
         flt_mist_ff  <= 1'b0;
         mister_ff    <= 1'b0;
         heater_ff    <= 1'b0;
      end else begin
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            tick_ff      <= tick_in;
            sec_ff       <= sec_in;
            min_ff       <= min_in;
            hour_ff      <= hour_in;
            mist_act_ff  <= mist_act_in;
            mist_en_ff   <= mist_en_in;
            burst_el_ff  <= burst_el_in;
            wait_el_ff   <= wait_el_in;
            attempts_ff  <= attempts_in;
            heat_act_ff  <= heat_act_in;
            heat_en_ff   <= heat_en_in;
            flt_warm_ff  <= flt_warm_in;
            flt_cold_ff  <= flt_cold_in;
            flt_mist_ff  <= flt_mist_in;
            mister_ff    <= mister_in;
            heater_ff    <= heater_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* tb/tb_climate_mist_heat_controller_top.sv */
// ----------------------------------------------------------------------------
// tb_climate_mist_heat_controller_top
// Self-checking bench for the climate mist/heat controller. A scoreboard
// object mirrors the tick clock, the mist burst sequencer, the heater and the
// fault latches. Each accepted request beat is stepped through that model and
// the status beat it predicts is queued. Each status beat taken from the block
// is compared field by field with the oldest queued one. Stimulus is a short
// directed opening, then random phases under several register settings,
// including a stretch at one tick per second so that the minutes roll over. A
// directed tail and a short fault-laden run close the test. Both handshake
// sides idle at random, and the status side also holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module tb_climate_mist_heat_controller_top;

   localparam logic [1:0] REQ_NONE     = 2'd0;
   localparam logic [1:0] REQ_RESERVED = 2'd3;
   localparam int         CsrDw        = cmh_pkg::CsrDataWidth;

   class climate_scoreboard;
      logic [6:0]        hum_setpoint;
      logic signed [9:0] temp_setpoint;
      logic [6:0]        hum_margin;
      logic [7:0]        ticks_per_sec;
      logic [7:0]        burst_len;
      logic [15:0]       wait_len;
      logic [3:0]        attempt_max;

      int tick_cnt, sec_cnt, min_cnt, hour_cnt;
      int burst_secs, wait_secs, attempts;
      bit mist_active, mist_en, heat_active, heat_en;
      bit warm_latch, cold_latch, gave_up;
      bit mister_drive, heater_drive;

      cmh_pkg::rsp_beat_type expected_status[$];
      int errors;

      function new();
         hum_setpoint  = cmh_pkg::RST_HUMIDITY_SETPOINT;
         temp_setpoint = cmh_pkg::RST_TEMPERATURE_SETPOINT;
         hum_margin    = cmh_pkg::RST_HUMIDITY_MARGIN;
         ticks_per_sec = cmh_pkg::RST_TICKS_PER_SECOND;
         burst_len     = cmh_pkg::RST_BURST_SECONDS;
         wait_len      = cmh_pkg::RST_WAIT_SECONDS;
         attempt_max   = cmh_pkg::RST_ATTEMPT_LIMIT;
      endfunction

      function void write_reg(logic [cmh_pkg::CsrIndexWidth-1:0] idx,
                              logic [cmh_pkg::CsrDataWidth-1:0] val);
         case (idx)
            cmh_pkg::CSR_HUMIDITY_SETPOINT:    hum_setpoint  = val[6:0];
            cmh_pkg::CSR_TEMPERATURE_SETPOINT: temp_setpoint = val[9:0];
            cmh_pkg::CSR_HUMIDITY_MARGIN:      hum_margin    = val[6:0];
            cmh_pkg::CSR_TICKS_PER_SECOND:     ticks_per_sec = val[7:0];
            cmh_pkg::CSR_BURST_SECONDS:        burst_len     = val[7:0];
            cmh_pkg::CSR_WAIT_SECONDS:         wait_len      = val[15:0];
            cmh_pkg::CSR_ATTEMPT_LIMIT:        attempt_max   = val[3:0];
            default: ;
         endcase
      endfunction

      function void clear_mist();
         mist_active = 1'b0;
         burst_secs  = 0;
         wait_secs   = 0;
         attempts    = 0;
      endfunction

      function void note_tick(cmh_pkg::req_beat_type b);
         int                    temp, hum, tset, hum_floor;
         bit                    sec, bus, fault_now;
         cmh_pkg::rsp_beat_type status;
         temp      = $signed(b.warm_temperature);
         hum       = $signed(b.cold_humidity);
         tset      = temp_setpoint;
         hum_floor = int'(hum_setpoint) - int'(hum_margin);
         bus       = b.bus_fault;
         sec       = 1'b0;

         if (b.warm_sensor_fault) warm_latch = 1'b1;
         if (b.cold_sensor_fault) cold_latch = 1'b1;

         if (b.mist_request == cmh_pkg::REQ_ENABLE) mist_en = 1'b1;
         else if (b.mist_request == cmh_pkg::REQ_DISABLE) mist_en = 1'b0;
         if (b.heat_request == cmh_pkg::REQ_ENABLE) heat_en = 1'b1;
         else if (b.heat_request == cmh_pkg::REQ_DISABLE) heat_en = 1'b0;

         if (tick_cnt + 1 >= int'(ticks_per_sec)) begin
            tick_cnt = 0;
            sec      = 1'b1;
            if (sec_cnt >= int'(cmh_pkg::SECOND_TOP)) begin
               sec_cnt = 0;
               if (min_cnt >= int'(cmh_pkg::MINUTE_TOP)) begin
                  min_cnt = 0;
                  if (hour_cnt >= int'(cmh_pkg::HOUR_TOP)) hour_cnt = 0;
                  else hour_cnt++;
               end else begin
                  min_cnt++;
               end
            end else begin
               sec_cnt++;
            end
         end else begin
            tick_cnt = (tick_cnt + 1) & 8'hFF;
         end

         if (mist_en) begin
            if (hum >= 0) begin
               if (hum < hum_floor) begin
                  if (mist_active) begin
                     if (sec && burst_secs < 255) burst_secs++;
                     if (burst_secs >= int'(burst_len)) begin
                        mist_active = 1'b0;
                        burst_secs  = 0;
                        if (attempts < 15) attempts++;
                     end
                  end else begin
                     if (sec && wait_secs < 65535) wait_secs++;
                     if (attempts == 0 || wait_secs >= int'(wait_len)) begin
                        if (attempts >= int'(attempt_max)) begin
                           mist_en = 1'b0;
                           gave_up = 1'b1;
                        end else begin
                           mist_active = 1'b1;
                           wait_secs   = 0;
                        end
                     end
                  end
               end else begin
                  clear_mist();
               end
            end else begin
               mist_en = 1'b0;
            end
         end else begin
            clear_mist();
         end

         if (heat_en) begin
            if (temp >= 0) begin
               if (heat_active) begin
                  if (temp > tset) heat_active = 1'b0;
               end else if (temp < tset) begin
                  heat_active = 1'b1;
               end
            end else begin
               heat_en = 1'b0;
            end
         end else begin
            heat_active = 1'b0;
         end

         fault_now = warm_latch || cold_latch || gave_up || bus;
         if (bus) begin
            heat_en = 1'b0;
            mist_en = 1'b0;
         end
         if (warm_latch) heat_en = 1'b0;
         if (cold_latch || gave_up) mist_en = 1'b0;

         if (sec) begin
            mister_drive = mist_active;
            heater_drive = heat_active;
         end

         status.mister_on     = mister_drive;
         status.heater_on     = heater_drive;
         status.mist_enabled  = mist_en;
         status.heat_enabled  = heat_en;
         status.mist_gave_up  = gave_up;
         status.any_fault     = fault_now;
         status.second_pulse  = sec;
         status.clock_hours   = 5'(hour_cnt);
         status.clock_minutes = 6'(min_cnt);
         status.clock_seconds = 6'(sec_cnt);
         expected_status.push_back(status);
      endfunction

      function void compare_field(string field, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_status(cmh_pkg::rsp_beat_type got);
         cmh_pkg::rsp_beat_type want;
         if (expected_status.size() == 0) begin
            errors++;
            $display("%0t: status beat with none expected, actual %h", $time, got);
            return;
         end
         want = expected_status.pop_front();
         compare_field("mister_on",     want.mister_on,     got.mister_on);
         compare_field("heater_on",     want.heater_on,     got.heater_on);
         compare_field("mist_enabled",  want.mist_enabled,  got.mist_enabled);
         compare_field("heat_enabled",  want.heat_enabled,  got.heat_enabled);
         compare_field("mist_gave_up",  want.mist_gave_up,  got.mist_gave_up);
         compare_field("any_fault",     want.any_fault,     got.any_fault);
         compare_field("second_pulse",  want.second_pulse,  got.second_pulse);
         compare_field("clock_hours",   want.clock_hours,   got.clock_hours);
         compare_field("clock_minutes", want.clock_minutes, got.clock_minutes);
         compare_field("clock_seconds", want.clock_seconds, got.clock_seconds);
      endfunction

      function int pending();
         return expected_status.size();
      endfunction
   endclass

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [cmh_pkg::ReqDataWidth-1:0]  req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [cmh_pkg::RspDataWidth-1:0]  rsp_tdata;
   logic                              csr_wen    = 1'b0;
   logic [cmh_pkg::CsrIndexWidth-1:0] csr_index  = '0;
   logic [cmh_pkg::CsrDataWidth-1:0]  csr_wdata  = '0;

   climate_scoreboard sb;
   int tx_idle_pct   = 10;
   int rx_idle_pct   = 10;
   int stall_request = 0;

   climate_mist_heat_controller_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_tick(cmh_pkg::req_beat_type'(
               req_tdata[$bits(cmh_pkg::req_beat_type)-1:0]));
         if (rsp_tvalid && rsp_tready)
            sb.check_status(cmh_pkg::rsp_beat_type'(rsp_tdata));
      end
   end

   // status side: random back-pressure, plus one long hold-off on request
   initial begin : receiver
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (stall_request > 0) begin
            hold          = stall_request;
            stall_request = 0;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   function automatic cmh_pkg::req_beat_type make_tick(input int temp, input int hum,
                                                       input bit warm, input bit cold,
                                                       input bit bus,
                                                       input logic [1:0] mreq,
                                                       input logic [1:0] hreq);
      cmh_pkg::req_beat_type b;
      b.warm_temperature  = 10'(temp);
      b.cold_humidity     = 8'(hum);
      b.warm_sensor_fault = warm;
      b.cold_sensor_fault = cold;
      b.bus_fault         = bus;
      b.mist_request      = mreq;
      b.heat_request      = hreq;
      return b;
   endfunction

   function automatic logic [1:0] random_request();
      int pick;
      pick = $urandom_range(99);
      if (pick < 6) return cmh_pkg::REQ_ENABLE;
      else if (pick < 8) return cmh_pkg::REQ_DISABLE;
      else if (pick < 10) return REQ_RESERVED;
      else return REQ_NONE;
   endfunction

   function automatic cmh_pkg::req_beat_type random_tick(input int thr, input bit dry,
                                                         input bit with_faults);
      cmh_pkg::req_beat_type b;
      int pick, lo;
      pick = $urandom_range(99);
      if (pick < 15)
         b.warm_temperature = 10'($urandom_range(1023));
      else if (pick < 40)
         b.warm_temperature = 10'(int'($urandom_range(315)) - 49);
      else
         b.warm_temperature = 10'(int'(sb.temp_setpoint) + int'($urandom_range(8)) - 4);
      lo   = (thr < 0) ? 0 : thr;
      pick = $urandom_range(99);
      if (pick < 8)            b.cold_humidity = 8'($urandom_range(255));
      else if (dry && thr > 0) b.cold_humidity = 8'($urandom_range(thr - 1, 0));
      else if (lo > 100)       b.cold_humidity = 8'($urandom_range(127, lo));
      else                     b.cold_humidity = 8'($urandom_range(100, lo));
      b.warm_sensor_fault = with_faults && ($urandom_range(9) == 0);
      b.cold_sensor_fault = with_faults && ($urandom_range(9) == 0);
      b.bus_fault         = ($urandom_range(49) == 0);
      b.mist_request      = random_request();
      b.heat_request      = random_request();
      return b;
   endfunction

   // entered and left at a falling edge; valid stays up between beats
   task automatic send_tick(input cmh_pkg::req_beat_type b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(cmh_pkg::ReqDataWidth - $bits(cmh_pkg::req_beat_type)){1'b0}}, b};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [cmh_pkg::CsrIndexWidth-1:0] idx,
                            input logic [cmh_pkg::CsrDataWidth-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [6:0] hum_set, input logic [9:0] temp_set,
                               input logic [6:0] margin, input logic [7:0] tps,
                               input logic [7:0] burst, input logic [15:0] pause,
                               input logic [3:0] attempts);
      write_reg(cmh_pkg::CSR_HUMIDITY_SETPOINT,    CsrDw'(hum_set));
      write_reg(cmh_pkg::CSR_TEMPERATURE_SETPOINT, CsrDw'(temp_set));
      write_reg(cmh_pkg::CSR_HUMIDITY_MARGIN,      CsrDw'(margin));
      write_reg(cmh_pkg::CSR_TICKS_PER_SECOND,     CsrDw'(tps));
      write_reg(cmh_pkg::CSR_BURST_SECONDS,        CsrDw'(burst));
      write_reg(cmh_pkg::CSR_WAIT_SECONDS,         pause);
      write_reg(cmh_pkg::CSR_ATTEMPT_LIMIT,        CsrDw'(attempts));
      csr_wen <= 1'b0;
   endtask

   // alternating dry and humid stretches so bursts and waits actually run
   task automatic run_phase(input int n_items, input int max_dry, input bit with_faults);
      int thr, left;
      bit dry;
      thr  = int'(sb.hum_setpoint) - int'(sb.hum_margin);
      left = 0;
      dry  = 1'b0;
      repeat (n_items) begin
         if (left == 0) begin
            dry  = !dry;
            left = dry ? $urandom_range(max_dry, 1) : $urandom_range(30, 1);
         end
         left--;
         send_tick(random_tick(thr, dry, with_faults));
      end
   endtask

   initial begin : stimulus
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every tick a second, zero-length bursts and waits
      program_regs(7'd60, 10'sd100, 7'd10, 8'd0, 8'd0, 16'd0, 4'd15);
      send_tick(make_tick(50, 20, 0, 0, 0, cmh_pkg::REQ_ENABLE, cmh_pkg::REQ_ENABLE));
      send_tick(make_tick(266, 20, 0, 0, 0, REQ_RESERVED, REQ_RESERVED));
      send_tick(make_tick(-49, 20, 0, 0, 0, REQ_NONE, REQ_NONE));
      send_tick(make_tick(100, 100, 0, 0, 0, REQ_NONE, cmh_pkg::REQ_ENABLE));
      send_tick(make_tick(0, -1, 0, 0, 0, REQ_NONE, REQ_NONE));
      send_tick(make_tick(101, 0, 0, 0, 0, cmh_pkg::REQ_ENABLE, REQ_NONE));
      send_tick(make_tick(99, 49, 0, 0, 1, cmh_pkg::REQ_ENABLE, cmh_pkg::REQ_ENABLE));
      send_tick(make_tick(511, 127, 0, 0, 0, cmh_pkg::REQ_ENABLE, cmh_pkg::REQ_ENABLE));
      send_tick(make_tick(-512, -128, 0, 0, 0, cmh_pkg::REQ_ENABLE, cmh_pkg::REQ_ENABLE));
      send_tick(make_tick(-1, 50, 0, 0, 0, cmh_pkg::REQ_ENABLE, cmh_pkg::REQ_ENABLE));
      send_tick(make_tick(100, 49, 0, 0, 0, REQ_NONE, cmh_pkg::REQ_ENABLE));
      repeat (4) send_tick(make_tick(10, 0, 0, 0, 0, REQ_NONE, REQ_NONE));
      send_tick(make_tick(10, 10, 0, 0, 0, cmh_pkg::REQ_DISABLE, cmh_pkg::REQ_DISABLE));
      send_tick(make_tick(10, 10, 0, 0, 0, REQ_NONE, REQ_NONE));
      settle();

      program_regs(7'd70, 10'sd75, 7'd10, 8'd3, 8'd2, 16'd4, 4'd15);
      stall_request = 300;
      run_phase(300, 60, 1'b0);
      settle();

      program_regs(7'd127, 10'h1FF, 7'd0, 8'd0, 8'd0, 16'd0, 4'd15);
      run_phase(250, 20, 1'b0);
      settle();

      program_regs(7'd100, 10'h200, 7'd20, 8'd255, 8'd255, 16'hFFFF, 4'd1);
      run_phase(200, 200, 1'b0);
      settle();

      // negative humidity floor: misting can never start
      program_regs(7'd0, 10'sd0, 7'd100, 8'd1, 8'd1, 16'd1, 4'd15);
      run_phase(150, 40, 1'b0);
      settle();

      program_regs(7'd50, 10'sd266, 7'd5, 8'd2, 8'd1, 16'd2, 4'd15);
      run_phase(200, 40, 1'b0);
      settle();

      // one tick per second with no idling, long enough for a minute rollover
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      program_regs(7'd70, 10'sd75, 7'd10, 8'd1, 8'd3, 16'd300, 4'd15);
      run_phase(150, 200, 1'b0);
      settle();
      tx_idle_pct = 10;
      rx_idle_pct = 10;

      // short attempt budget: long dry spells end in a give-up
      program_regs(7'd70, 10'sd75, 7'd10, 8'd1, 8'd1, 16'd1, 4'd3);
      run_phase(120, 60, 1'b0);
      settle();

      program_regs(7'd70, 10'sd75, 7'd10, 8'd1, 8'd1, 16'd1, 4'd0);
      send_tick(make_tick(50, 10, 0, 0, 0, cmh_pkg::REQ_ENABLE, REQ_NONE));
      settle();
      program_regs(7'd70, 10'sd75, 7'd10, 8'd1, 8'd1, 16'd1, 4'd1);
      send_tick(make_tick(50, 10, 0, 0, 0, cmh_pkg::REQ_ENABLE, cmh_pkg::REQ_ENABLE));
      send_tick(make_tick(50, 10, 0, 0, 0, REQ_NONE, REQ_NONE));
      send_tick(make_tick(50, 10, 1, 0, 0, REQ_NONE, cmh_pkg::REQ_ENABLE));
      send_tick(make_tick(50, 10, 0, 0, 0, REQ_NONE, cmh_pkg::REQ_ENABLE));
      send_tick(make_tick(50, 10, 0, 1, 0, cmh_pkg::REQ_ENABLE, REQ_NONE));
      run_phase(40, 10, 1'b1);

      settle();
      repeat (8) @(negedge clock);
      if (sb.errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("simulation failed");
      $finish;
   end

endmodule
